// ----- rtl/core/i2s_pkg.sv -----
// Shared types, constants and the segment table for the integer to seven-segment frame block.
package i2s_pkg;

   // Widths of the integer path and of the packed decimal result.
   localparam int VALUE_W = 32;
   localparam int BCD_DIGITS = 10;
   localparam int BCD_W = 4 * BCD_DIGITS;
   localparam int TEXT_MAX = 11;
   localparam int CNT_W = 4;

   // The double-dabble conversion runs eight shift steps per pipeline stage.
   localparam int DABBLE_STEPS = 8;
   localparam int DABBLE_STAGES = VALUE_W / DABBLE_STEPS;

   // Configuration register indexes and their reset values.
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ADDRESS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MINUS_CODE = 4'd1;
   localparam logic [7:0] RESET_START_ADDRESS = 8'h08;
   localparam logic [7:0] RESET_MINUS_CODE = 8'h40;

   // One value on its way through the conversion pipeline.
   typedef struct packed {
      logic neg;
      logic [VALUE_W-1:0] bin;
      logic [BCD_W-1:0] bcd;
   } conv_type;

   // Standard segment pattern for the decimal digits.
   function automatic logic [7:0] digit_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      case (digit)
         4'd0: pat = 8'h3F;
         4'd1: pat = 8'h06;
         4'd2: pat = 8'h5B;
         4'd3: pat = 8'h4F;
         4'd4: pat = 8'h66;
         4'd5: pat = 8'h6D;
         4'd6: pat = 8'h7D;
         4'd7: pat = 8'h07;
         4'd8: pat = 8'h7F;
         4'd9: pat = 8'h6F;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

endpackage

// ----- rtl/core/i2s_dabble.sv -----
// One slice of the binary to packed decimal conversion: eight add-3 and shift steps.
module i2s_dabble import i2s_pkg::*; (
   input  conv_type d,
   output conv_type q
);

   logic [BCD_W-1:0] bcd;
   logic [VALUE_W-1:0] bin;

   // Each step corrects every digit of five or more, then shifts one binary bit in.
   always_comb begin
      bcd = d.bcd;
      bin = d.bin;
      for (int s = 0; s < DABBLE_STEPS; s++) begin
         for (int j = 0; j < BCD_DIGITS; j++) begin
            if (bcd[j*4 +: 4] >= 4'd5) begin
               bcd[j*4 +: 4] = bcd[j*4 +: 4] + 4'd3;
            end
         end
         bcd = {bcd[BCD_W-2:0], bin[VALUE_W-1]};
         bin = {bin[VALUE_W-2:0], 1'b0};
      end
      q.neg = d.neg;
      q.bin = bin;
      q.bcd = bcd;
   end

endmodule

// ----- rtl/core/i2s_serializer.sv -----
// Frame serializer: sends the address byte and then one segment code per kept character.
module i2s_serializer import i2s_pkg::*; #(
   parameter int LIMIT = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  conv_type   in_data,
   input  logic [7:0] start_address,
   input  logic [7:0] minus_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_address,
   output logic       rsp_last
);

   localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(LIMIT);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] nd_ff, nd_in;
   logic [CNT_W-1:0] keep_ff, keep_in;
   logic             neg_ff, neg_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             addr_ff, addr_in;
   logic             last_ff, last_in;

   logic             out_adv;
   logic             emit;
   logic             at_end;
   logic             load;
   logic [CNT_W-1:0] nd_new;
   logic [CNT_W-1:0] len_new;
   logic [CNT_W-1:0] sel;
   logic [3:0]       digit;

   // Handshake between the pipeline, the frame position and the output register.
   always_comb begin
      out_adv = !rsp_valid_ff || rsp_ready;
      emit = busy_ff && out_adv;
      at_end = (pos_ff == keep_ff);
      in_ready = !busy_ff || (emit && at_end);
      load = in_valid && in_ready;
   end

   // Count of significant digits (zero still shows one digit) and the text length before the limit.
   always_comb begin
      nd_new = CNT_W'(1);
      for (int j = 0; j < BCD_DIGITS; j++) begin
         if (in_data.bcd[j*4 +: 4] != 4'd0) begin
            nd_new = CNT_W'(j + 1);
         end
      end
      len_new = nd_new + CNT_W'(in_data.neg);
   end

   // Pick the digit for the character at the current position, leftmost first.
   always_comb begin
      sel = nd_ff + CNT_W'(neg_ff) - pos_ff;
      digit = 4'd0;
      for (int j = 0; j < BCD_DIGITS; j++) begin
         if (sel == CNT_W'(j)) begin
            digit = bcd_ff[j*4 +: 4];
         end
      end
   end

   // Next values of the frame state and the output register.
   always_comb begin
      busy_in = busy_ff;
      pos_in = pos_ff;
      nd_in = nd_ff;
      keep_in = keep_ff;
      neg_in = neg_ff;
      bcd_in = bcd_ff;
      rsp_valid_in = rsp_valid_ff;
      byte_in = byte_ff;
      addr_in = addr_ff;
      last_in = last_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         pos_in = pos_ff + CNT_W'(1);
         addr_in = (pos_ff == '0);
         last_in = at_end;
         if (pos_ff == '0) begin
            byte_in = start_address;
         end else if (neg_ff && pos_ff == CNT_W'(1)) begin
            byte_in = minus_code;
         end else begin
            byte_in = digit_pattern(digit);
         end
         if (at_end) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         pos_in = '0;
         nd_in = nd_new;
         keep_in = (len_new > LIMIT_CNT) ? LIMIT_CNT : len_new;
         neg_in = in_data.neg;
         bcd_in = in_data.bcd;
      end
   end

   // Control state resets; the payload does not need to.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff <= pos_in;
      nd_ff <= nd_in;
      keep_ff <= keep_in;
      neg_ff <= neg_in;
      bcd_ff <= bcd_in;
      byte_ff <= byte_in;
      addr_ff <= addr_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_is_address = addr_ff;
   assign rsp_last = last_ff;

endmodule

// ----- rtl/core/int_to_seven_segment_frame.sv -----
// Top level: signed integer to seven-segment display frame with a conversion pipeline.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_ready  req_value (32-bit signed)
//   rsp      out        rsp_valid / rsp_ready  rsp_out_byte, rsp_is_address, rsp_last
//   csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// A value reaches the serializer after six register stages (input, magnitude and four
// conversion stages). The serializer sets the rate: a frame is the address byte and
// min(text length, LIMIT) characters, LIMIT being MAX_DIGITS clamped to 1..11 (two to nine
// bytes with the default), and a waiting next frame follows the last byte without a gap.
// Reset loads the configuration registers with 8 and 64 and empties every stage.
// With rsp_ready low the output register holds and up to six values wait behind the serializer.
module int_to_seven_segment_frame import i2s_pkg::*; #(
   parameter int MAX_DIGITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic signed [31:0]     req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_is_address,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   localparam int LIMIT = (MAX_DIGITS < 1) ? 1 : ((MAX_DIGITS > TEXT_MAX) ? TEXT_MAX : MAX_DIGITS);
   localparam int NSTG = 1 + DABBLE_STAGES;

   logic [7:0]         start_address_ff, start_address_in;
   logic [7:0]         minus_code_ff, minus_code_in;
   logic               in_valid_ff, in_valid_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               stg_valid_ff [NSTG];
   logic               stg_valid_in [NSTG];
   conv_type           stg_data_ff [NSTG];
   conv_type           stg_data_in [NSTG];
   conv_type           dab_q [DABBLE_STAGES];
   logic               stg_ready [NSTG+1];
   conv_type           mag;
   logic               in_ready;
   logic               ser_ready;

   // Configuration registers; writes to other indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      start_address_in = start_address_ff;
      minus_code_in = minus_code_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_START_ADDRESS: start_address_in = csr_wdata;
            CSR_MINUS_CODE: minus_code_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Each stage takes a new value when it is empty or its successor takes its current one.
   always_comb begin
      stg_ready[NSTG] = ser_ready;
      for (int i = NSTG - 1; i >= 0; i--) begin
         stg_ready[i] = !stg_valid_ff[i] || stg_ready[i+1];
      end
      in_ready = !in_valid_ff || stg_ready[0];
   end

   assign req_ready = in_ready;

   // Sign and magnitude; the most negative value keeps its true magnitude as unsigned.
   always_comb begin
      mag.neg = value_ff[VALUE_W-1];
      mag.bin = value_ff[VALUE_W-1] ? (VALUE_W'(0) - value_ff) : value_ff;
      mag.bcd = '0;
   end

   // Conversion slices between the pipeline registers.
   for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
      i2s_dabble u_dabble (
         .d (stg_data_ff[g]),
         .q (dab_q[g])
      );
   end

   // Next values of the input register and the pipeline stages.
   always_comb begin
      in_valid_in = in_valid_ff;
      value_in = value_ff;
      if (in_ready) begin
         in_valid_in = req_valid;
      end
      if (req_valid && in_ready) begin
         value_in = req_value;
      end

      for (int i = 0; i < NSTG; i++) begin
         stg_valid_in[i] = stg_valid_ff[i];
         stg_data_in[i] = stg_data_ff[i];
      end
      if (stg_ready[0]) begin
         stg_valid_in[0] = in_valid_ff;
         stg_data_in[0] = mag;
      end
      for (int i = 1; i < NSTG; i++) begin
         if (stg_ready[i]) begin
            stg_valid_in[i] = stg_valid_ff[i-1];
            stg_data_in[i] = dab_q[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_address_ff <= RESET_START_ADDRESS;
         minus_code_ff <= RESET_MINUS_CODE;
         in_valid_ff <= 1'b0;
         for (int i = 0; i < NSTG; i++) begin
            stg_valid_ff[i] <= 1'b0;
         end
      end else begin
         start_address_ff <= start_address_in;
         minus_code_ff <= minus_code_in;
         in_valid_ff <= in_valid_in;
         for (int i = 0; i < NSTG; i++) begin
            stg_valid_ff[i] <= stg_valid_in[i];
         end
      end
      value_ff <= value_in;
      for (int i = 0; i < NSTG; i++) begin
         stg_data_ff[i] <= stg_data_in[i];
      end
   end

   // Frame serializer with the output register.
   i2s_serializer #(
      .LIMIT (LIMIT)
   ) u_serializer (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (stg_valid_ff[NSTG-1]),
      .in_ready       (ser_ready),
      .in_data        (stg_data_ff[NSTG-1]),
      .start_address  (start_address_ff),
      .minus_code     (minus_code_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_is_address (rsp_is_address),
      .rsp_last       (rsp_last)
   );

   // An address byte never closes a frame, since every frame has at least one character.
   a_addr_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_address |-> !rsp_last)
      else $error("address byte marked as last");

   // The first character follows the address transaction in the very next cycle.
   a_char_after_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_is_address |=> rsp_valid && !rsp_is_address)
      else $error("no character after the address byte");

   // After the last byte, the next byte shown opens a new frame.
   a_addr_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid || rsp_is_address)
      else $error("frame did not restart with an address byte");

   // A character that is not last is followed at once by another character.
   a_frame_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_is_address && !rsp_last |=> rsp_valid && !rsp_is_address)
      else $error("gap or address inside a frame");

endmodule
